### rtl/core/pvd_pkg.sv
// Shared package of the prefixed varint decoder.
// Holds the size constants, the status codes and the state and result structs.
// No dependencies; every other file of the block uses it.
package pvd_pkg;

  localparam int MAX_PREFIX_BYTES = 8;
  localparam int VALUE_W          = 64;
  localparam int BYTE_W           = 8;
  localparam int LEFT_W           = 4;
  localparam int COUNT_W          = BYTE_W + 1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LONG  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef struct packed {
    logic [LEFT_W-1:0]  bytes_left;
    logic [VALUE_W-1:0] acc;
  } state_t;

  typedef struct packed {
    logic               emit;
    status_t            status;
    logic [VALUE_W-1:0] value;
  } result_t;

endpackage

### rtl/core/pvd_if.sv
// Handshake interfaces of the prefixed varint decoder: byte input and result output.
// Depends on pvd_pkg for the status type.
interface pvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;

  modport source (output valid, output in_byte, output buffer_end, input ready);
  modport sink (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface pvd_out_if;
  logic              valid;
  logic              ready;
  logic [63:0]       value;
  pvd_pkg::status_t  status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

### rtl/core/prefixed_varint_decoder.sv
// Top level of the length-prefixed 64-bit unsigned varint decoder.
// Depends on pvd_pkg, the interfaces in pvd_if and the step logic in pvd_step.
//
// Usage: the encoded stream enters on in_s, one byte per transaction, with
// buffer_end set on the last byte available in the buffer. A lead byte up to
// 0x7f is a value by itself; a larger lead byte announces 256 minus the byte
// payload bytes, big-endian. Each finished value or error leaves on out_m as
// one transaction carrying value and status (ok, prefix too long, truncated);
// value is zero whenever status reports an error. Payload bytes that do not
// finish a value produce no transaction.
//
// Pipeline: a byte accepted on in_s is held in the input register; the step logic
// then updates the decoder state and fills the result register in the same cycle,
// and the result shows on out_m from there. Throughput is one byte per cycle while
// the receiver takes results without stalling.
//
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to waiting for a lead byte. When the receiver stalls, the result
// stays on out_m; the input register still drains one byte into it once the
// result is taken, and in_s.ready drops only while the held byte cannot move.
module prefixed_varint_decoder (
  input  logic              clk,
  input  logic              rst_n,
  pvd_in_if.sink            in_s,
  pvd_out_if.source         out_m
);

  // Input register stage.
  logic                           s1_valid_r, s1_valid_nxt;
  logic [pvd_pkg::BYTE_W-1:0]     s1_byte_r, s1_byte_nxt;
  logic                           s1_last_r, s1_last_nxt;

  // Decoder state.
  pvd_pkg::state_t                state_r, state_nxt;
  pvd_pkg::state_t                step_state;
  pvd_pkg::result_t               step_res;

  // Result register.
  logic                           out_valid_r, out_valid_nxt;
  pvd_pkg::result_t               out_res_r, out_res_nxt;

  logic                           out_free;
  logic                           s1_go;
  logic                           in_accept;

  // The held byte moves on whenever the result register is empty or being read.
  assign out_free  = !out_valid_r || out_m.ready;
  assign s1_go     = s1_valid_r && out_free;
  assign in_s.ready = !s1_valid_r || s1_go;
  assign in_accept = in_s.valid && in_s.ready;

  pvd_step u_step (
    .cur     (state_r),
    .byte_in (s1_byte_r),
    .last    (s1_last_r),
    .nxt     (step_state),
    .res     (step_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    s1_last_nxt  = s1_last_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
      s1_byte_nxt  = in_s.in_byte;
      s1_last_nxt  = in_s.buffer_end;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (s1_go) begin
      state_nxt     = step_state;
      out_valid_nxt = step_res.emit;
      out_res_nxt   = step_res;
    end else if (out_m.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    s1_last_r <= s1_last_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_m.valid  = out_valid_r;
  assign out_m.value  = out_res_r.value;
  assign out_m.status = out_res_r.status;

endmodule

### rtl/core/pvd_step.sv
// Combinational decode step: one byte against the current decoder state.
// Depends on pvd_pkg for constants, the state struct and the result struct.
module pvd_step (
  input  pvd_pkg::state_t                    cur,
  input  logic [pvd_pkg::BYTE_W-1:0]         byte_in,
  input  logic                               last,
  output pvd_pkg::state_t                    nxt,
  output pvd_pkg::result_t                   res
);

  logic [pvd_pkg::COUNT_W-1:0] count;
  logic [pvd_pkg::VALUE_W-1:0] acc_sh;
  logic [pvd_pkg::LEFT_W-1:0]  left_dec;

  // A lead byte above 0x7f announces 256 minus the byte payload bytes.
  assign count    = pvd_pkg::COUNT_W'(1 << pvd_pkg::BYTE_W)
                    - {1'b0, byte_in};
  assign acc_sh   = {cur.acc[pvd_pkg::VALUE_W-pvd_pkg::BYTE_W-1:0], byte_in};
  assign left_dec = cur.bytes_left - pvd_pkg::LEFT_W'(1);

  always_comb begin
    nxt        = cur;
    res.emit   = 1'b0;
    res.status = pvd_pkg::ST_OK;
    res.value  = '0;
    if (cur.bytes_left == '0) begin
      if (!byte_in[pvd_pkg::BYTE_W-1]) begin
        res.emit  = 1'b1;
        res.value = pvd_pkg::VALUE_W'(byte_in);
      end else if (count > pvd_pkg::COUNT_W'(pvd_pkg::MAX_PREFIX_BYTES)) begin
        res.emit   = 1'b1;
        res.status = pvd_pkg::ST_TOO_LONG;
      end else if (last) begin
        res.emit   = 1'b1;
        res.status = pvd_pkg::ST_TRUNCATED;
      end else begin
        nxt.bytes_left = count[pvd_pkg::LEFT_W-1:0];
        nxt.acc        = '0;
      end
    end else begin
      if (left_dec == '0) begin
        res.emit       = 1'b1;
        res.value      = acc_sh;
        nxt.bytes_left = '0;
        nxt.acc        = '0;
      end else if (last) begin
        res.emit       = 1'b1;
        res.status     = pvd_pkg::ST_TRUNCATED;
        nxt.bytes_left = '0;
        nxt.acc        = '0;
      end else begin
        nxt.bytes_left = left_dec;
        nxt.acc        = acc_sh;
      end
    end
  end

endmodule

### rtl/core/pvd_chk.sv
// Port-level checker for the prefixed varint decoder, bound to the top level.
// Depends on pvd_pkg for the status codes.
module pvd_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [63:0]       out_value,
  input pvd_pkg::status_t  out_status
);

  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pvd_pkg::ST_OK) |-> out_value == '0)
    else $error("error result carries a nonzero value");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == pvd_pkg::ST_OK) || (out_status == pvd_pkg::ST_TOO_LONG)
                  || (out_status == pvd_pkg::ST_TRUNCATED))
    else $error("result with undefined status code");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("stalled result changed or vanished");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind prefixed_varint_decoder pvd_chk u_pvd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_m.valid),
  .out_ready  (out_m.ready),
  .out_value  (out_m.value),
  .out_status (out_m.status)
);

### bench/prefixed_varint_decoder_tb.sv
// Self-checking testbench of the prefixed varint decoder: directed cases, then a random stream.
// Needs the RTL only: pvd_pkg, the pvd_in_if and pvd_out_if interfaces, the top level and pvd_step.
// Results are checked against an in-bench decoder model, in order and field by field.
module prefixed_varint_decoder_tb;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 5;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int REPORT_LIMIT  = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BYTES  = 480;

  // One decoded value or error, as the result channel carries it.
  typedef struct packed {
    logic [pvd_pkg::VALUE_W-1:0] value;
    pvd_pkg::status_t            status;
  } decoded_t;

  logic clk;
  logic rst_n;

  pvd_in_if  in_ch ();
  pvd_out_if out_ch ();

  prefixed_varint_decoder dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_m (out_ch)
  );

  // Decoder model state: payload bytes still awaited and the value built so far.
  logic [pvd_pkg::LEFT_W-1:0]  model_left;
  logic [pvd_pkg::VALUE_W-1:0] model_acc;

  // Decoded results that the block still owes, oldest first.
  decoded_t owed_results[$];

  int          send_idle_pct;
  int          recv_idle_pct;
  int          bytes_sent;
  int          mismatches;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Runs one accepted byte through the decoder model and records the result it causes.
  task automatic decode_byte(input logic [pvd_pkg::BYTE_W-1:0] b, input logic last);
    int count;
    if (model_left == '0) begin
      // Waiting for a lead byte.
      if (b <= 8'h7f) begin
        owed_results.push_back('{value: {{(pvd_pkg::VALUE_W - pvd_pkg::BYTE_W){1'b0}}, b},
                                 status: pvd_pkg::ST_OK});
      end else begin
        count = 256 - int'(b);
        if (count > pvd_pkg::MAX_PREFIX_BYTES) begin
          // The bytes after an oversized prefix are not skipped.
          owed_results.push_back('{value: '0, status: pvd_pkg::ST_TOO_LONG});
        end else if (last) begin
          owed_results.push_back('{value: '0, status: pvd_pkg::ST_TRUNCATED});
        end else begin
          model_left = pvd_pkg::LEFT_W'(count);
          model_acc  = '0;
        end
      end
    end else begin
      // Payload bytes arrive big-endian.
      model_acc  = {model_acc[pvd_pkg::VALUE_W-pvd_pkg::BYTE_W-1:0], b};
      model_left = model_left - pvd_pkg::LEFT_W'(1);
      if (model_left == '0) begin
        // Completion wins over buffer_end on the final payload byte.
        owed_results.push_back('{value: model_acc, status: pvd_pkg::ST_OK});
        model_acc = '0;
      end else if (last) begin
        owed_results.push_back('{value: '0, status: pvd_pkg::ST_TRUNCATED});
        model_left = '0;
        model_acc  = '0;
      end
    end
  endtask

  // Offers one byte, after random idle cycles, and holds it until the block takes it.
  // The valid line is left high on return so back-to-back transactions need no gap.
  task automatic send_byte(input logic [pvd_pkg::BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.buffer_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  // Single-byte values, with and without buffer_end, at both ends of the literal range.
  task automatic test_literal_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h40, 1'b1);
  endtask

  // The longest prefix of all and the shortest that is too long, once with buffer_end.
  // The byte after each is decoded as a fresh lead byte.
  task automatic test_oversized_prefix();
    send_byte(8'h80, 1'b0);
    send_byte(8'hf7, 1'b1);
    send_byte(8'h7e, 1'b0);
  endtask

  // A one-byte payload of zero, then a full eight-byte payload of all ones that ends
  // exactly at the buffer end, which must still decode as a complete value.
  task automatic test_complete_payloads();
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hf8, 1'b0);
    for (int k = 1; k <= pvd_pkg::MAX_PREFIX_BYTES; k++)
      send_byte(8'hff, k == pvd_pkg::MAX_PREFIX_BYTES);
  endtask

  // Buffer ending on a valid lead byte, then inside a payload; the decoder must recover.
  task automatic test_truncated_values();
    send_byte(8'hfe, 1'b1);
    send_byte(8'hfc, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h7f, 1'b0);
  endtask

  // Mostly well-formed values with random payloads, some cut short by buffer_end,
  // mixed with literals, oversized prefixes and raw noise bytes.
  task automatic run_random_stream(input int n_bytes);
    int first;
    int kind;
    int count;
    int cut;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        count = ($urandom_range(3) == 0) ? pvd_pkg::MAX_PREFIX_BYTES
                                         : $urandom_range(pvd_pkg::MAX_PREFIX_BYTES, 1);
        // cut 0 ends the buffer on the lead byte, cut k on payload byte k.
        cut = ($urandom_range(9) == 0) ? $urandom_range(count) : -1;
        send_byte(8'(256 - count), cut == 0);
        if (cut != 0) begin
          for (int k = 1; k <= count; k++) begin
            send_byte(($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hff : 8'h00)
                                               : 8'($urandom_range(255)),
                      (k == cut) || (k == count && $urandom_range(3) == 0));
            if (k == cut) break;
          end
        end
      end else if (kind < 75) begin
        send_byte(8'($urandom_range(127)), 1'($urandom_range(1)));
      end else if (kind < 87) begin
        send_byte(8'($urandom_range(247, 128)), 1'($urandom_range(1)));
      end else begin
        send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      end
    end
  endtask

  // Three idle profiles: a slow receiver, then a slow sender, then full rate both ways.
  task automatic test_random_stream();
    send_idle_pct = 34;
    recv_idle_pct = 50;
    run_random_stream(RANDOM_BYTES);
    send_idle_pct = 50;
    recv_idle_pct = 34;
    run_random_stream(RANDOM_BYTES);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_stream(RANDOM_BYTES);
  endtask

  // The receiver stalls at random; the draw is made at every edge, reset included.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Each result transaction is matched against the oldest owed result. Sampling at the
  // edge sees the values from before it, the same ones the block acts on.
  always @(posedge clk) begin : check_results
    decoded_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: value=%h status=%0d", out_ch.value, out_ch.status);
      end else begin
        want = owed_results.pop_front();
        if (out_ch.value !== want.value || out_ch.status !== want.status) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                     want.value, want.status, out_ch.value, out_ch.status);
        end
      end
    end
  end

  // Watchdog: far above the slowest correct run of this stimulus.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               owed_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.in_byte    = '0;
    in_ch.buffer_end = 1'b0;
    out_ch.ready     = 1'b0;
    model_left       = '0;
    model_acc        = '0;
    send_idle_pct    = 34;
    recv_idle_pct    = 50;
    bytes_sent       = 0;
    mismatches       = 0;
    cycle_count      = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_literal_bytes();
    test_oversized_prefix();
    test_complete_payloads();
    test_truncated_values();
    test_random_stream();

    // The last byte was taken at this edge, so valid drops right away. Wait for every
    // owed result, then allow for latency so that any extra result would still be caught.
    in_ch.valid <= 1'b0;
    recv_idle_pct = 0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/pvd_pkg.sv
rtl/core/pvd_if.sv
rtl/core/pvd_step.sv
rtl/core/prefixed_varint_decoder.sv
rtl/core/pvd_chk.sv
bench/prefixed_varint_decoder_tb.sv
